// ===== rtl/lpfr_pkg.sv =====
package lpfr_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_OPCODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_CAPACITY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TOTAL       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_FRAMES  = 3'd4;

    localparam logic [1:0] MODE_OPCODE_LEN4 = 2'd0;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_FINAL   = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic        last;
    } out_t;

endpackage

// ===== rtl/length_prefixed_frame_receiver_core.sv =====
// Length-prefixed frame receiver.
// Input channel (in_valid/in_stall/in_data): one request per received UART
// byte (req_type 0) or per frame tick (req_type 1). Depending on frame_mode
// a frame opens with an opcode byte and a 4-byte big-endian length, a 4-byte
// length only, or a 2-byte length; payload bytes then stream out.
// Output channel (out_valid/out_stall/out_data): at most one result per
// request: payload byte, final byte, empty frame, or an error (wrong opcode,
// bad length, timeout). last marks every end of frame.
// Config port (cfg_we/cfg_index/cfg_data): write only while idle.
// Timing: a request is taken every cycle while in_stall is low; its result
// is registered in the output register, or in the skid entry while that is
// stalled. The frame state register is the only loop, updated per request.
// Stall: an output register plus a one-entry skid buffer; in_stall rises only
// once the skid entry is occupied, so throughput is one request per cycle
// while out_stall is low.
// Reset: phase idle, all counters zero, registers back to defaults
// (mode 0, opcode 0, capacity and maximum 65535, timeout 60).
module length_prefixed_frame_receiver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lpfr_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lpfr_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lpfr_pkg::*;

    // configuration
    logic [1:0]  frame_mode_reg;
    logic [7:0]  expected_opcode_reg;
    logic [15:0] buffer_capacity_reg;
    logic [15:0] max_total_reg;
    logic [15:0] timeout_frames_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [31:0] len_acc_reg, len_acc_next;
    logic [1:0]  len_seen_reg, len_seen_next;
    logic [15:0] payload_cnt_reg, payload_cnt_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;
    logic [15:0] accepted_len_reg, accepted_len_next;

    // output buffering
    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;

    logic        in_accept;
    logic        pop;
    logic        has_res;
    out_t        res;

    logic [31:0] acc_base;
    logic [1:0]  seen_base;
    logic [31:0] acc_shift;
    logic [1:0]  seen_inc;
    logic        two_byte;
    logic        len_done;
    logic [31:0] len_val;
    logic [15:0] cap;
    logic        len_bad;
    logic [15:0] ticks_inc;
    logic [16:0] idx_plus1;

    assign in_accept = in_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg      <= MODE_OPCODE_LEN4;
            expected_opcode_reg <= 8'd0;
            buffer_capacity_reg <= 16'hFFFF;
            max_total_reg       <= 16'hFFFF;
            timeout_frames_reg  <= 16'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_MODE:      frame_mode_reg      <= cfg_data[1:0];
                CFG_EXPECTED_OPCODE: expected_opcode_reg <= cfg_data[7:0];
                CFG_BUFFER_CAPACITY: buffer_capacity_reg <= cfg_data;
                CFG_MAX_TOTAL:       max_total_reg       <= cfg_data;
                CFG_TIMEOUT_FRAMES:  timeout_frames_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // length byte handling; a new frame starts from an empty accumulator
    always_comb
    begin
        acc_base  = (phase_reg == PH_IDLE) ? 32'd0 : len_acc_reg;
        seen_base = (phase_reg == PH_IDLE) ? 2'd0 : len_seen_reg;
        acc_shift = {acc_base[23:0], in_data.rx_byte};
        seen_inc  = seen_base + 2'd1;
        two_byte  = frame_mode_reg[1];
        // count wraps to zero after the fourth byte
        len_done  = (seen_inc == 2'd0) || (two_byte && (seen_inc >= 2'd2));
        len_val   = two_byte ? {16'd0, acc_shift[15:0]} : acc_shift;
        cap       = (buffer_capacity_reg < max_total_reg) ? buffer_capacity_reg
                                                          : max_total_reg;
        len_bad   = (len_val > {16'd0, cap}) || ((len_val == 32'd0) && !two_byte);
        ticks_inc = (idle_ticks_reg == 16'hFFFF) ? idle_ticks_reg
                                                 : idle_ticks_reg + 16'd1;
        idx_plus1 = {1'b0, payload_cnt_reg} + 17'd1;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        len_acc_next      = len_acc_reg;
        len_seen_next     = len_seen_reg;
        payload_cnt_next  = payload_cnt_reg;
        idle_ticks_next   = idle_ticks_reg;
        accepted_len_next = accepted_len_reg;
        has_res           = 1'b0;
        res               = '0;

        if (in_accept)
        begin
            if (in_data.req_type == REQ_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    idle_ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_frames_reg)
                    begin
                        has_res    = 1'b1;
                        res.status = ST_TIMEOUT;
                        res.last   = 1'b1;
                    end
                end
            end
            else
            begin
                idle_ticks_next = 16'd0;
                unique case (phase_reg) inside
                    PH_IDLE,
                    PH_LENGTH:
                    begin
                        if (phase_reg == PH_IDLE && frame_mode_reg == MODE_OPCODE_LEN4)
                        begin
                            phase_next       = PH_LENGTH;
                            len_acc_next     = 32'd0;
                            len_seen_next    = 2'd0;
                            payload_cnt_next = 16'd0;
                            if (in_data.rx_byte != expected_opcode_reg)
                            begin
                                has_res    = 1'b1;
                                res.status = ST_BADOP;
                                res.last   = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next    = PH_LENGTH;
                            len_acc_next  = acc_shift;
                            len_seen_next = seen_inc;
                            if (phase_reg == PH_IDLE)
                                payload_cnt_next = 16'd0;
                            if (len_done)
                            begin
                                if (len_bad)
                                begin
                                    has_res    = 1'b1;
                                    res.status = ST_BADLEN;
                                    res.last   = 1'b1;
                                end
                                else if (len_val == 32'd0)
                                begin
                                    has_res    = 1'b1;
                                    res.status = ST_EMPTY;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    phase_next        = PH_PAYLOAD;
                                    accepted_len_next = len_val[15:0];
                                    payload_cnt_next  = 16'd0;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        payload_cnt_next = idx_plus1[15:0];
                        has_res          = 1'b1;
                        res.data_byte    = in_data.rx_byte;
                        res.byte_index   = payload_cnt_reg;
                        res.frame_length = accepted_len_reg;
                        if (idx_plus1 >= {1'b0, accepted_len_reg})
                        begin
                            res.status = ST_FINAL;
                            res.last   = 1'b1;
                        end
                        else
                            res.status = ST_BYTE;
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end

            // every end of frame, good or bad, clears the frame state
            if (has_res && res.last)
            begin
                phase_next        = PH_IDLE;
                len_acc_next      = 32'd0;
                len_seen_next     = 2'd0;
                payload_cnt_next  = 16'd0;
                idle_ticks_next   = 16'd0;
                accepted_len_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            len_acc_reg      <= 32'd0;
            len_seen_reg     <= 2'd0;
            payload_cnt_reg  <= 16'd0;
            idle_ticks_reg   <= 16'd0;
            accepted_len_reg <= 16'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            len_acc_reg      <= len_acc_next;
            len_seen_reg     <= len_seen_next;
            payload_cnt_reg  <= payload_cnt_next;
            idle_ticks_reg   <= idle_ticks_next;
            accepted_len_reg <= accepted_len_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= has_res;
            end
            else
                out_valid_reg <= has_res;
        end
        else if (has_res)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= res;
            end
            else
                out_data_reg <= res;
        end
        else if (has_res)
            skid_data_reg <= res;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |->
            (payload_cnt_reg == 16'd0 && idle_ticks_reg == 16'd0 && len_acc_reg == 32'd0))
        else $error("frame state not cleared in idle");

    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_cnt_reg < accepted_len_reg))
        else $error("payload count beyond accepted length");

    a_mid_frame_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.last) |-> (out_data_reg.status == ST_BYTE))
        else $error("non-final result that is not a payload byte");

endmodule
